### hw/rtl/mfmd_pkg.sv
// Shared types and constants for the motor feedback multi-turn decoder.
package mfmd_pkg;

	localparam int unsigned HALF_RANGE_DEF = 4096;
	localparam int unsigned MID_DEPTH_DEF  = 2;
	localparam int unsigned OUT_DEPTH_DEF  = 2;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_NUMBER      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREES_PER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET      = 2'd2;

	localparam logic [3:0]  MOTOR_NUMBER_RST      = 4'd1;
	localparam logic [31:0] DEGREES_PER_COUNT_RST = 32'd737280;

	localparam logic signed [15:0] SPEED_DEADBAND = 16'sd3;

	typedef struct packed {
		logic [10:0] frame_id;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [7:0]  byte3;
		logic [7:0]  byte4;
		logic [7:0]  byte5;
		logic [7:0]  byte6;
	} frame_t;

	typedef struct packed {
		logic [15:0]        position_raw;
		logic signed [15:0] speed_filtered;
		logic signed [15:0] current_reading;
		logic [7:0]         temperature;
		logic signed [31:0] turn_count;
		logic signed [47:0] angle_fixed;
		logic signed [31:0] angle_whole;
	} result_t;

	// Decoded frame handed from the front to the back
	typedef struct packed {
		logic [15:0]        position;
		logic signed [15:0] speed;
		logic signed [15:0] current;
		logic [7:0]         temperature;
		logic signed [31:0] turns;
	} meas_t;

endpackage

### hw/rtl/mfmd_fifo.sv
// Small register queue used between the decoder stages and at the result side.
module mfmd_fifo #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rd_data
);
	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/mfmd_front.sv
// Front end: accepts frames, filters by motor number, unpacks and tracks turns.
module mfmd_front #(
	parameter int unsigned HALF_RANGE = mfmd_pkg::HALF_RANGE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  mfmd_pkg::frame_t frame,
	input  logic [3:0]      motor_number,
	output logic            q_push,
	input  logic            q_full,
	output mfmd_pkg::meas_t q_data
);
	import mfmd_pkg::*;

	localparam logic signed [17:0] HalfPos = 18'(HALF_RANGE);
	localparam logic signed [17:0] HalfNeg = -18'(HALF_RANGE);

	logic [15:0]        prev_pos_q;
	logic signed [31:0] turns_q;
	logic [15:0]        pos;
	logic signed [15:0] speed_raw;
	logic signed [17:0] diff;
	logic signed [31:0] turns_next;
	logic               take;

	assign full      = q_full;
	assign take      = push && !q_full && (frame.frame_id[3:0] == motor_number);
	assign q_push    = take;
	assign pos       = {frame.byte0, frame.byte1};
	assign speed_raw = {frame.byte2, frame.byte3};
	assign diff      = $signed({2'b00, pos}) - $signed({2'b00, prev_pos_q});

	always_comb begin
		priority if (diff > HalfPos) begin
			turns_next = turns_q - 32'sd1;
		end else if (diff < HalfNeg) begin
			turns_next = turns_q + 32'sd1;
		end else begin
			turns_next = turns_q;
		end
	end

	always_comb begin
		q_data.position    = pos;
		q_data.speed       = ((speed_raw <= SPEED_DEADBAND) && (speed_raw >= -SPEED_DEADBAND))
			? 16'sd0 : speed_raw;
		q_data.current     = {frame.byte4, frame.byte5};
		q_data.temperature = frame.byte6;
		q_data.turns       = turns_next;
	end

	// Turn state advances only on frames addressed to this motor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q <= '0;
			turns_q    <= '0;
		end else if (take) begin
			prev_pos_q <= pos;
			turns_q    <= turns_next;
		end
	end

endmodule

### hw/rtl/mfmd_back.sv
// Back end: three-stage angle datapath (scale, sum, saturate) with stall.
module mfmd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	output logic              q_pop,
	input  mfmd_pkg::meas_t   q_data,
	input  logic [31:0]       degrees_per_count,
	input  logic signed [47:0] start_offset,
	output logic              o_push,
	input  logic              o_full,
	output mfmd_pkg::result_t o_data
);
	import mfmd_pkg::*;

	localparam logic signed [59:0] FixMax = 60'sh7FFF_FFFF_FFFF;
	localparam logic signed [59:0] FixMin = -60'sh8000_0000_0000;
	localparam logic signed [43:0] WholeMax = 44'sh000_7FFF_FFFF;
	localparam logic signed [43:0] WholeMin = -44'sh000_8000_0000;

	logic               adv;
	logic               v_s1, v_s2, v_s3;
	meas_t              m_s1, m_s2, m_s3;
	logic [47:0]        prod_s1;
	logic signed [40:0] tdeg_s1;
	logic signed [59:0] sum_s2;
	logic signed [47:0] fixed_s3;
	logic signed [31:0] whole_s3;

	logic signed [40:0] t41;
	logic signed [40:0] tdeg;
	logic signed [59:0] sum;
	logic signed [43:0] whole_trunc;
	logic signed [47:0] fixed_sat;
	logic signed [31:0] whole_sat;

	// Advance the whole pipeline whenever the result queue has room
	assign adv    = !o_full;
	assign q_pop  = adv && !q_empty;
	assign o_push = adv && v_s3;

	// turns * 360 as 256 + 64 + 32 + 8
	assign t41  = 41'(q_data.turns);
	assign tdeg = (t41 <<< 8) + (t41 <<< 6) + (t41 <<< 5) + (t41 <<< 3);

	assign sum = $signed({{3{tdeg_s1[40]}}, tdeg_s1, 16'h0000})
		+ $signed({20'h00000, prod_s1[47:8]})
		- $signed({{12{start_offset[47]}}, start_offset});

	// Truncate toward zero: floor, then bump negative values with a fraction
	assign whole_trunc = sum_s2[59:16]
		+ 44'(sum_s2[59] && (sum_s2[15:0] != 16'h0000));

	always_comb begin
		priority if (sum_s2 > FixMax) begin
			fixed_sat = FixMax[47:0];
		end else if (sum_s2 < FixMin) begin
			fixed_sat = FixMin[47:0];
		end else begin
			fixed_sat = sum_s2[47:0];
		end
		priority if (whole_trunc > WholeMax) begin
			whole_sat = WholeMax[31:0];
		end else if (whole_trunc < WholeMin) begin
			whole_sat = WholeMin[31:0];
		end else begin
			whole_sat = whole_trunc[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1     <= q_data;
			prod_s1  <= q_data.position * degrees_per_count;
			tdeg_s1  <= tdeg;
			m_s2     <= m_s1;
			sum_s2   <= sum;
			m_s3     <= m_s2;
			fixed_s3 <= fixed_sat;
			whole_s3 <= whole_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		o_data.position_raw    = m_s3.position;
		o_data.speed_filtered  = m_s3.speed;
		o_data.current_reading = m_s3.current;
		o_data.temperature     = m_s3.temperature;
		o_data.turn_count      = m_s3.turns;
		o_data.angle_fixed     = fixed_s3;
		o_data.angle_whole     = whole_s3;
	end

endmodule

### hw/rtl/motor_feedback_multiturn_decoder_top.sv
// A frame's result shows (empty low) after middle queue and three angle stages.
// Throughput: one frame per cycle; the front takes a frame every cycle while the
// middle queue has room, and the three-stage angle datapath stalls only on a full
// result queue. Frames for another motor are accepted and dropped with no result.
// Reset clears the turn counter, last position, queues and loads register defaults.
// Top level: configuration registers, front end, middle queue, back end, result queue.
module motor_feedback_multiturn_decoder_top #(
	parameter int unsigned HALF_RANGE = mfmd_pkg::HALF_RANGE_DEF,
	parameter int unsigned MID_DEPTH  = mfmd_pkg::MID_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH  = mfmd_pkg::OUT_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  mfmd_pkg::frame_t                frame,
	input  logic                            pop,
	output logic                            empty,
	output mfmd_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mfmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfmd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mfmd_pkg::*;

	logic [3:0]         motor_number_q;
	logic [31:0]        degrees_per_count_q;
	logic signed [47:0] start_offset_q;

	logic    mid_push, mid_full, mid_pop, mid_empty;
	meas_t   mid_wr, mid_rd;
	logic    out_push, out_full;
	result_t out_wr;

	assign cfg_ready = 1'b1;

	// Unknown register indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_number_q      <= MOTOR_NUMBER_RST;
			degrees_per_count_q <= DEGREES_PER_COUNT_RST;
			start_offset_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MOTOR_NUMBER:      motor_number_q      <= cfg_data[3:0];
				REG_DEGREES_PER_COUNT: degrees_per_count_q <= cfg_data[31:0];
				REG_START_OFFSET:      start_offset_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	mfmd_front #(
		.HALF_RANGE(HALF_RANGE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.frame       (frame),
		.motor_number(motor_number_q),
		.q_push      (mid_push),
		.q_full      (mid_full),
		.q_data      (mid_wr)
	);

	mfmd_fifo #(
		.DEPTH(MID_DEPTH),
		.WIDTH($bits(meas_t))
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.full   (mid_full),
		.wr_data(mid_wr),
		.pop    (mid_pop),
		.empty  (mid_empty),
		.rd_data(mid_rd)
	);

	mfmd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (mid_empty),
		.q_pop            (mid_pop),
		.q_data           (mid_rd),
		.degrees_per_count(degrees_per_count_q),
		.start_offset     (start_offset_q),
		.o_push           (out_push),
		.o_full           (out_full),
		.o_data           (out_wr)
	);

	mfmd_fifo #(
		.DEPTH(OUT_DEPTH),
		.WIDTH($bits(result_t))
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.full   (out_full),
		.wr_data(out_wr),
		.pop    (pop),
		.empty  (empty),
		.rd_data(result)
	);

endmodule

### hw/rtl/mfmd_checker.sv
// Port-level checks on the result stream of the decoder, bound to the top level.
module mfmd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pop,
	input logic              empty,
	input mfmd_pkg::result_t result
);
	import mfmd_pkg::*;

	localparam logic signed [47:0] FixMax = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] FixMin = -48'sh8000_0000_0000;

	logic signed [31:0] whole_from_fixed;
	logic               fixed_in_range;
	logic [31:0]        turn_step;

	// Whole degrees of an unsaturated angle that fits 32 bits
	assign whole_from_fixed = result.angle_fixed[47:16]
		+ 32'(result.angle_fixed[47] && (result.angle_fixed[15:0] != 16'h0000));
	assign fixed_in_range = (result.angle_fixed != FixMax) && (result.angle_fixed != FixMin)
		&& (result.angle_fixed[47:47] == result.angle_fixed[46:46])
		&& ((result.angle_fixed[47:31] == 17'h00000) || (result.angle_fixed[47:31] == 17'h1FFFF));

	assign turn_step = result.turn_count;

	a_dead_band: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !((result.speed_filtered >= 16'sd1 && result.speed_filtered <= SPEED_DEADBAND)
			|| (result.speed_filtered <= -16'sd1 && result.speed_filtered >= -SPEED_DEADBAND)))
		else $error("speed inside dead band not zeroed");

	a_whole_match: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && fixed_in_range) |-> (result.angle_whole == whole_from_fixed))
		else $error("whole angle disagrees with fixed angle");

	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) ##1 !empty |->
			((turn_step - $past(turn_step)) == 32'h0000_0000
			|| (turn_step - $past(turn_step)) == 32'h0000_0001
			|| (turn_step - $past(turn_step)) == 32'hFFFF_FFFF))
		else $error("turn count moved by more than one between results");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished before transaction");

endmodule

bind motor_feedback_multiturn_decoder_top mfmd_checker u_mfmd_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.pop   (pop),
	.empty (empty),
	.result(result)
);

### tb/motor_feedback_multiturn_decoder_top_tb.sv
// Self-checking testbench for the motor feedback multi-turn decoder top level.
module motor_feedback_multiturn_decoder_top_tb;

	import mfmd_pkg::*;

	localparam int          HALF_SPAN     = int'(HALF_RANGE_DEF);
	localparam int          DEADBAND      = 3;
	localparam int          IDLE_PCT      = 26;
	localparam int          SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int          FRAME_W       = $bits(frame_t);

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam longint TURN_FIXED = longint'(360) * 65536;
	localparam longint ANGLE_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ANGLE_MIN  = -ANGLE_MAX - 1;
	localparam longint WHOLE_MAX  = 64'sd2147483647;
	localparam longint WHOLE_MIN  = -WHOLE_MAX - 1;

	typedef enum logic [1:0] {
		ROW_PREDICTED,
		ROW_TYPED,
		ROW_REG
	} row_kind_e;

	typedef struct packed {
		row_kind_e             kind;
		logic [10:0]           id;
		logic [15:0]           pos;
		logic [15:0]           spd_in;
		logic [15:0]           cur;
		logic [7:0]            temp;
		logic [15:0]           spd_out;
		logic [31:0]           turns;
		logic [47:0]           angle;
		logic [31:0]           whole;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_data;
	} opening_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	frame_t                frame     = '0;
	logic                  pop       = 1'b0;
	logic                  empty;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Decoder model state and its copy of the registers
	logic [3:0]         motor_sel     = MOTOR_NUMBER_RST;
	logic [31:0]        count_scale   = DEGREES_PER_COUNT_RST;
	logic signed [47:0] zero_offset   = '0;
	logic [15:0]        last_position = '0;
	logic signed [31:0] turn_total    = '0;

	result_t      awaited_results[$];
	opening_row_t opening[$];

	bit          no_idle = 1'b0;
	logic [15:0] shaft;
	int          spin_dir = 1;

	int          errors;
	int          frames_sent;
	int          foreign_frames;
	int          results_checked;
	int          reg_writes;
	int unsigned cycles;

	motor_feedback_multiturn_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.frame     (frame),
		.pop       (pop),
		.empty     (empty),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the model by one frame; returns 0 when the frame is for another motor
	function automatic bit decode_feedback(input frame_t f, output result_t r);
		logic [15:0]        position;
		logic signed [15:0] speed;
		logic signed [15:0] current;
		int                 step;
		longint             product;
		longint             sum;
		longint             fixed;
		longint             whole;
		r = '0;
		if (f.frame_id[3:0] != motor_sel)
			return 1'b0;
		position = {f.byte0, f.byte1};
		speed    = {f.byte2, f.byte3};
		current  = {f.byte4, f.byte5};
		if (speed >= -DEADBAND && speed <= DEADBAND)
			speed = '0;
		step = int'(position) - int'(last_position);
		if (step > HALF_SPAN)
			turn_total = turn_total - 1;
		else if (step < -HALF_SPAN)
			turn_total = turn_total + 1;
		last_position = position;
		product = longint'((64'(position) * 64'(count_scale)) >> 8);
		sum = longint'(turn_total) * TURN_FIXED + product - longint'(zero_offset);
		fixed = sum;
		if (fixed > ANGLE_MAX)
			fixed = ANGLE_MAX;
		else if (fixed < ANGLE_MIN)
			fixed = ANGLE_MIN;
		whole = sum / 65536;
		if (whole > WHOLE_MAX)
			whole = WHOLE_MAX;
		else if (whole < WHOLE_MIN)
			whole = WHOLE_MIN;
		r.position_raw    = position;
		r.speed_filtered  = speed;
		r.current_reading = current;
		r.temperature     = f.byte6;
		r.turn_count      = turn_total;
		r.angle_fixed     = fixed[47:0];
		r.angle_whole     = whole[31:0];
		return 1'b1;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_MOTOR_NUMBER: begin
				motor_sel = value[3:0];
			end
			REG_DEGREES_PER_COUNT: begin
				count_scale = value[31:0];
			end
			REG_START_OFFSET: begin
				zero_offset = value;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic opening_row_t frame_row(input logic [10:0] id, input logic [15:0] pos,
		input logic [15:0] spd, input logic [15:0] cur, input logic [7:0] temp);
		opening_row_t row;
		row        = '0;
		row.kind   = ROW_PREDICTED;
		row.id     = id;
		row.pos    = pos;
		row.spd_in = spd;
		row.cur    = cur;
		row.temp   = temp;
		return row;
	endfunction

	function automatic opening_row_t typed_row(input logic [10:0] id, input logic [15:0] pos,
		input logic [15:0] spd, input logic [15:0] cur, input logic [7:0] temp,
		input logic [15:0] spd_out, input logic [31:0] turns, input logic [47:0] angle,
		input logic [31:0] whole);
		opening_row_t row;
		row         = frame_row(id, pos, spd, cur, temp);
		row.kind    = ROW_TYPED;
		row.spd_out = spd_out;
		row.turns   = turns;
		row.angle   = angle;
		row.whole   = whole;
		return row;
	endfunction

	function automatic opening_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		opening_row_t row;
		row          = '0;
		row.kind     = ROW_REG;
		row.reg_idx  = idx;
		row.reg_data = value;
		return row;
	endfunction

	// Encoder walk: mostly spinning in one direction, with threshold jumps and jitter
	function automatic frame_t random_frame(input bit for_us);
		frame_t f;
		int     pick;
		f = frame_t'(FRAME_W'({$urandom, $urandom, $urandom}));
		if (!for_us) begin
			f.frame_id[3:0] = motor_sel ^ 4'($urandom_range(1, 15));
			return f;
		end
		f.frame_id[3:0] = motor_sel;
		pick = $urandom_range(99);
		if (pick < 5)
			spin_dir = -spin_dir;
		if (pick < 60)
			shaft = shaft + 16'(spin_dir * int'($urandom_range(0, HALF_SPAN - 96)));
		else if (pick < 75)
			shaft = shaft + 16'(spin_dir * (HALF_SPAN + int'($urandom_range(0, 1))));
		else if (pick < 85)
			shaft = shaft - 16'(spin_dir * int'($urandom_range(0, 16)));
		else
			shaft = 16'($urandom);
		{f.byte0, f.byte1} = shaft;
		if ($urandom_range(99) < 30)
			{f.byte2, f.byte3} = 16'(int'($urandom_range(0, 10)) - 5);
		return f;
	endfunction

	task automatic send_frame(input frame_t f, input bit typed, input result_t typed_want);
		result_t predicted;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		frame <= f;
		@(posedge clk);
		while (full)
			@(posedge clk);
		frames_sent++;
		if (decode_feedback(f, predicted))
			awaited_results.push_back(typed ? typed_want : predicted);
		else
			foreign_frames++;
	endtask

	// Hold off until every result is out and dropped frames have left the pipeline
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		apply_reg(idx, value);
		reg_writes++;
	endtask

	task automatic run_phase(input logic [3:0] motor, input logic [31:0] scale,
		input logic [47:0] offset_v, input int count, input bit calm);
		int matched;
		bit for_us;
		write_reg(REG_MOTOR_NUMBER, CFG_DATA_W'(motor));
		write_reg(REG_DEGREES_PER_COUNT, CFG_DATA_W'(scale));
		write_reg(REG_START_OFFSET, offset_v);
		no_idle = calm;
		matched = 0;
		while (matched < count) begin
			for_us = $urandom_range(99) >= 15;
			send_frame(random_frame(for_us), 1'b0, '0);
			if (for_us)
				matched++;
		end
		no_idle = 1'b0;
	endtask

	task automatic check_field(input string field, input logic [47:0] want_v,
		input logic [47:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %h got %h", $time, field, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_side
		result_t want;
		if (arst_n && pop && !empty) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none expected, got %h", $time, result);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				results_checked++;
				check_field("position_raw", 48'(want.position_raw), 48'(result.position_raw));
				check_field("speed_filtered", 48'(want.speed_filtered),
					48'(result.speed_filtered));
				check_field("current_reading", 48'(want.current_reading),
					48'(result.current_reading));
				check_field("temperature", 48'(want.temperature), 48'(result.temperature));
				check_field("turn_count", 48'(want.turn_count), 48'(result.turn_count));
				check_field("angle_fixed", want.angle_fixed, result.angle_fixed);
				check_field("angle_whole", 48'(want.angle_whole), 48'(result.angle_whole));
			end
		end
		pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				awaited_results.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		opening = '{
			// deadband edges and first frame against position zero
			typed_row(11'h001, 16'h0000, 16'h0003, 16'h8000, 8'hFF,
				16'h0000, 32'h0000_0000, 48'd0, 32'd0),
			typed_row(11'h7F1, 16'h1000, 16'hFFFD, 16'h7FFF, 8'h00,
				16'h0000, 32'h0000_0000, 48'd11796480, 32'd180),
			frame_row(11'h7F0, 16'hFFFF, 16'h1234, 16'h5678, 8'h42),
			// jump just over half the range, upward then back
			typed_row(11'h011, 16'h2001, 16'h0004, 16'h0000, 8'h55,
				16'h0004, 32'hFFFF_FFFF, 48'd2880, 32'd0),
			typed_row(11'h021, 16'h0000, 16'hFFFC, 16'hFFFF, 8'hAA,
				16'hFFFC, 32'h0000_0000, 48'd0, 32'd0),
			frame_row(11'h001, 16'hFFFF, 16'h7FFF, 16'h0001, 8'h80),
			frame_row(11'h041, 16'hEFFF, 16'h8000, 16'hC000, 8'h01),
			frame_row(11'h081, 16'hDFFE, 16'h00FF, 16'h3FFF, 8'h7F),
			frame_row(11'h00F, 16'h0000, 16'h0000, 16'h0000, 8'h00),
			typed_row(11'h101, 16'h0000, 16'h0001, 16'h1234, 8'h19,
				16'h0000, 32'h0000_0001, 48'd23592960, 32'd360),
			reg_row(REG_UNUSED, '1),
			typed_row(11'h001, 16'h0000, 16'h0000, 16'h0000, 8'h00,
				16'h0000, 32'h0000_0001, 48'd23592960, 32'd360),
			// widest scale against the most negative offset saturates high
			reg_row(REG_MOTOR_NUMBER, 48'd0),
			reg_row(REG_DEGREES_PER_COUNT, 48'hFFFF_FFFF),
			reg_row(REG_START_OFFSET, 48'h8000_0000_0000),
			frame_row(11'h001, 16'h1111, 16'h2222, 16'h3333, 8'h44),
			typed_row(11'h000, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF,
				16'h7FFF, 32'h0000_0000, 48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF),
			// zero scale against the most positive offset, then saturate low
			reg_row(REG_MOTOR_NUMBER, 48'd15),
			reg_row(REG_DEGREES_PER_COUNT, 48'd0),
			reg_row(REG_START_OFFSET, 48'h7FFF_FFFF_FFFF),
			typed_row(11'h00F, 16'hFFFF, 16'h0000, 16'h0000, 8'h00,
				16'h0000, 32'h0000_0000, 48'h8000_0000_0001, 32'h8000_0001),
			frame_row(11'h7FF, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF),
			frame_row(11'h03F, 16'h8000, 16'h0005, 16'hFFFB, 8'h10),
			typed_row(11'h0FF, 16'hFFFF, 16'h8000, 16'h7FFF, 8'h00,
				16'h8000, 32'hFFFF_FFFF, 48'h8000_0000_0000, 32'h8000_0000)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening[i]) begin
			if (opening[i].kind == ROW_REG)
				write_reg(opening[i].reg_idx, opening[i].reg_data);
			else
				send_frame({opening[i].id, opening[i].pos, opening[i].spd_in,
					opening[i].cur, opening[i].temp},
					opening[i].kind == ROW_TYPED,
					{opening[i].pos, opening[i].spd_out, opening[i].cur, opening[i].temp,
					opening[i].turns, opening[i].angle, opening[i].whole});
		end

		shaft = last_position;
		run_phase(MOTOR_NUMBER_RST, DEGREES_PER_COUNT_RST, 48'd0, 100, 1'b0);
		run_phase(4'($urandom), $urandom, 48'({$urandom, $urandom}), 100, 1'b1);
		run_phase(4'd0, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, 75, 1'b0);
		run_phase(4'd15, 32'd0, 48'h8000_0000_0000, 75, 1'b0);
		run_phase(4'($urandom), $urandom, 48'({$urandom, $urandom}), 160, 1'b0);

		drain();

		$display("covered %0d frames (%0d for other motors) across %0d register writes",
			frames_sent, foreign_frames, reg_writes);
		$display("compared %0d decoded results, %0d mismatches", results_checked, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
hw/rtl/mfmd_pkg.sv
hw/rtl/mfmd_fifo.sv
hw/rtl/mfmd_front.sv
hw/rtl/mfmd_back.sv
hw/rtl/motor_feedback_multiturn_decoder_top.sv
hw/rtl/mfmd_checker.sv
tb/motor_feedback_multiturn_decoder_top_tb.sv
